// ===== sv/irpd_pkg.sv =====
// Package for the IR pulse-distance decoder: types, register indexes,
// reset values and frame layout constants. No dependencies.
package irpd_pkg;

    // Frame layout, counted in entries from the header mark
    localparam int unsigned FRAME_USED    = 99;  // header, 48 bit pairs, trailer
    localparam int unsigned PROTO_MIN_LEN = 49;
    localparam int unsigned HDR_SPACE_POS = 1;
    localparam int unsigned FIRST_BIT_POS = 2;
    localparam int unsigned TRAILER_POS   = 98;
    localparam int unsigned MISC_END_POS  = 35;  // spaces below this go to misc

    localparam int unsigned POS_W  = 7;
    localparam int unsigned DUR_W  = 17;
    localparam int unsigned TOL_W  = 12;
    localparam int unsigned TIME_W = 16;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned MISC_W = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Register reset values
    localparam logic [TOL_W-1:0]  RST_TOLERANCE    = 12'd300;
    localparam logic [TIME_W-1:0] RST_HEADER_MARK  = 16'd3502;
    localparam logic [TIME_W-1:0] RST_HEADER_SPACE = 16'd1750;
    localparam logic [TIME_W-1:0] RST_BIT_MARK     = 16'd460;
    localparam logic [TIME_W-1:0] RST_ONE_SPACE    = 16'd1200;
    localparam logic [TIME_W-1:0] RST_ZERO_SPACE   = 16'd460;

    typedef logic [POS_W-1:0] t_pos;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOLERANCE    = 3'd0,
        CFG_HEADER_MARK  = 3'd1,
        CFG_HEADER_SPACE = 3'd2,
        CFG_BIT_MARK     = 3'd3,
        CFG_ONE_SPACE    = 3'd4,
        CFG_ZERO_SPACE   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [TOL_W-1:0]  tolerance_us;
        logic [TIME_W-1:0] header_mark_us;
        logic [TIME_W-1:0] header_space_us;
        logic [TIME_W-1:0] bit_mark_us;
        logic [TIME_W-1:0] one_space_us;
        logic [TIME_W-1:0] zero_space_us;
    } t_cfg;

    typedef struct packed {
        logic              is_protocol;
        logic              decode_ok;
        logic [DATA_W-1:0] data_word;
        logic [MISC_W-1:0] misc_word;
    } t_res;

endpackage

// ===== sv/irpd_if.sv =====
// Valid/ready channel interfaces of the IR pulse-distance decoder.
// Depends on irpd_pkg for field widths.
interface irpd_in_if
    import irpd_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [DUR_W-1:0] duration_us;
    logic                    frame_last;

    modport source (output valid, output duration_us, output frame_last, input ready);
    modport sink   (input valid, input duration_us, input frame_last, output ready);
endinterface

interface irpd_out_if
    import irpd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              is_protocol;
    logic              decode_ok;
    logic [DATA_W-1:0] data_word;
    logic [MISC_W-1:0] misc_word;

    modport source (output valid, output is_protocol, output decode_ok,
                    output data_word, output misc_word, input ready);
    modport sink   (input valid, input is_protocol, input decode_ok,
                    input data_word, input misc_word, output ready);
endinterface

// ===== sv/ir_pulse_distance_decoder.sv =====
// Top level of the IR pulse-distance decoder: request register, frame core,
// result register. Depends on irpd_pkg, irpd_if, irpd_cfg, irpd_core.
//
//  Port       Dir  Handshake    Carries
//  i_req      in   valid/ready  duration_us (17b signed), frame_last
//  o_res      out  valid/ready  is_protocol, decode_ok, data_word, misc_word
//  i_cfg_*    in   write enable register index (3b), write data (16b)
//
// One request per cycle sustained while no frame end stalls; a frame's result
// passes the request register, then the result register.
// Synchronous active-low reset clears the frame state and restores defaults.
// Only a frame-ending request stalls, and only while the result register
// still holds an untaken result; ordinary entries flow past a blocked output.
module ir_pulse_distance_decoder
    import irpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    irpd_in_if.sink               i_req,
    irpd_out_if.source            o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg cfg;
    t_res core_res;

    logic                    r_in_vld;
    logic signed [DUR_W-1:0] r_in_dur;
    logic                    r_in_last;
    logic                    r_out_vld;
    t_res                    r_out;

    logic adv;
    logic in_ready;

    irpd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Advance the held request unless it ends a frame and the result slot is full
    assign adv      = r_in_vld && (!r_in_last || !r_out_vld || o_res.ready);
    assign in_ready = !r_in_vld || adv;
    assign i_req.ready = in_ready;

    irpd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (adv),
        .i_dur   (r_in_dur),
        .i_last  (r_in_last),
        .i_cfg   (cfg),
        .o_res   (core_res)
    );

    // Request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_ready) begin
            r_in_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_req.valid) begin
            r_in_dur  <= i_req.duration_us;
            r_in_last <= i_req.frame_last;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv && r_in_last) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_last) begin
            r_out <= core_res;
        end
    end

    assign o_res.valid       = r_out_vld;
    assign o_res.is_protocol = r_out.is_protocol;
    assign o_res.decode_ok   = r_out.decode_ok;
    assign o_res.data_word   = r_out.data_word;
    assign o_res.misc_word   = r_out.misc_word;

`ifndef SYNTHESIS
    a_last_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_in_last && r_out_vld && !o_res.ready) |-> !adv)
        else $error("frame end advanced into a full result register");
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> (r_in_vld && r_in_last && r_out_vld))
        else $error("request side stalled without a blocked frame end");
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(adv && r_in_last))
        else $error("result appeared without a frame end");
`endif

endmodule

// ===== sv/irpd_cfg.sv =====
// Configuration register bank: tolerance and expected durations.
// Depends on irpd_pkg.
module irpd_cfg
    import irpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write into the addressed register; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TOLERANCE:    n_cfg.tolerance_us    = i_cfg_data[TOL_W-1:0];
                CFG_HEADER_MARK:  n_cfg.header_mark_us  = i_cfg_data;
                CFG_HEADER_SPACE: n_cfg.header_space_us = i_cfg_data;
                CFG_BIT_MARK:     n_cfg.bit_mark_us     = i_cfg_data;
                CFG_ONE_SPACE:    n_cfg.one_space_us    = i_cfg_data;
                CFG_ZERO_SPACE:   n_cfg.zero_space_us   = i_cfg_data;
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tolerance_us    <= RST_TOLERANCE;
            r_cfg.header_mark_us  <= RST_HEADER_MARK;
            r_cfg.header_space_us <= RST_HEADER_SPACE;
            r_cfg.bit_mark_us     <= RST_BIT_MARK;
            r_cfg.one_space_us    <= RST_ONE_SPACE;
            r_cfg.zero_space_us   <= RST_ZERO_SPACE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/irpd_match.sv =====
// Duration compare: sign check plus absolute tolerance window.
// Depends on irpd_pkg.
module irpd_match
    import irpd_pkg::*;
(
    input  logic signed [DUR_W-1:0] i_dur,
    input  logic                    i_want_mark,
    input  logic [TIME_W-1:0]       i_expect,
    input  logic [TOL_W-1:0]        i_tol,
    output logic                    o_hit
);

    logic signed [DUR_W:0] mag;
    logic signed [DUR_W:0] expect_s;
    logic signed [DUR_W:0] diff;
    logic        [DUR_W:0] abs_diff;
    logic                  sign_ok;

    // Take the magnitude for the wanted polarity; zero matches neither
    always_comb begin
        sign_ok  = i_want_mark ? (i_dur > 0) : (i_dur < 0);
        mag      = i_want_mark ? (DUR_W+1)'(i_dur) : -((DUR_W+1)'(i_dur));
        expect_s = signed'({2'b00, i_expect});
        diff     = mag - expect_s;
        abs_diff = (diff < 0) ? unsigned'(-diff) : unsigned'(diff);
        o_hit    = sign_ok && (abs_diff <= (DUR_W+1)'(i_tol));
    end

endmodule

// ===== sv/irpd_core.sv =====
// Per-frame decode state: entry position, header verdict, bit error flag
// and the misc/data shift registers. Depends on irpd_pkg and irpd_match.
module irpd_core
    import irpd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic signed [DUR_W-1:0] i_dur,
    input  logic                    i_last,
    input  t_cfg                    i_cfg,
    output t_res                    o_res
);

    t_pos              r_pos;
    logic              r_hdr_ok;
    logic              r_bit_err;
    logic [MISC_W-1:0] r_misc;
    logic [DATA_W-1:0] r_data;

    t_pos              n_pos;
    logic              n_hdr_ok;
    logic              n_bit_err;
    logic [MISC_W-1:0] n_misc;
    logic [DATA_W-1:0] n_data;

    logic [TIME_W-1:0] mark_exp;
    logic [TIME_W-1:0] space_exp;
    logic              mark_hit;
    logic              space_hit;
    logic              zero_hit;
    logic              in_bits;
    logic              bit_val;
    logic              ok;

    // Expected values follow the entry position
    assign mark_exp  = (r_pos == '0) ? i_cfg.header_mark_us : i_cfg.bit_mark_us;
    assign space_exp = (r_pos == t_pos'(HDR_SPACE_POS)) ? i_cfg.header_space_us
                                                        : i_cfg.one_space_us;

    irpd_match u_mark (
        .i_dur       (i_dur),
        .i_want_mark (1'b1),
        .i_expect    (mark_exp),
        .i_tol       (i_cfg.tolerance_us),
        .o_hit       (mark_hit)
    );

    irpd_match u_space (
        .i_dur       (i_dur),
        .i_want_mark (1'b0),
        .i_expect    (space_exp),
        .i_tol       (i_cfg.tolerance_us),
        .o_hit       (space_hit)
    );

    irpd_match u_zero (
        .i_dur       (i_dur),
        .i_want_mark (1'b0),
        .i_expect    (i_cfg.zero_space_us),
        .i_tol       (i_cfg.tolerance_us),
        .o_hit       (zero_hit)
    );

    // Advance the frame state by one entry; an ambiguous space reads as a one
    always_comb begin
        in_bits   = (r_pos >= t_pos'(FIRST_BIT_POS)) && (r_pos < t_pos'(TRAILER_POS));
        bit_val   = space_hit;
        n_hdr_ok  = r_hdr_ok;
        n_bit_err = r_bit_err;
        n_misc    = r_misc;
        n_data    = r_data;
        if ((r_pos == '0) || (r_pos == t_pos'(FIRST_BIT_POS))) begin
            if (!mark_hit) n_hdr_ok = 1'b0;
        end
        if (r_pos == t_pos'(HDR_SPACE_POS)) begin
            if (!space_hit) n_hdr_ok = 1'b0;
        end
        if (in_bits) begin
            if (!r_pos[0]) begin
                if (!mark_hit) n_bit_err = 1'b1;
            end else begin
                if (!space_hit && !zero_hit) n_bit_err = 1'b1;
                if (r_pos < t_pos'(MISC_END_POS)) begin
                    n_misc = {r_misc[MISC_W-2:0], bit_val};
                end else begin
                    n_data = {r_data[DATA_W-2:0], bit_val};
                end
            end
        end
        n_pos = (r_pos < t_pos'(FRAME_USED)) ? r_pos + t_pos'(1) : r_pos;
    end

    // Verdicts see this entry's update
    always_comb begin
        ok                = (n_pos >= t_pos'(FRAME_USED)) && !n_bit_err;
        o_res.is_protocol = (n_pos >= t_pos'(PROTO_MIN_LEN)) && n_hdr_ok;
        o_res.decode_ok   = ok;
        o_res.data_word   = ok ? n_data : '0;
        o_res.misc_word   = ok ? n_misc : '0;
    end

    // Hold state between entries, clear it at frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_hdr_ok  <= 1'b1;
            r_bit_err <= 1'b0;
            r_misc    <= '0;
            r_data    <= '0;
        end else if (i_step) begin
            if (i_last) begin
                r_pos     <= '0;
                r_hdr_ok  <= 1'b1;
                r_bit_err <= 1'b0;
                r_misc    <= '0;
                r_data    <= '0;
            end else begin
                r_pos     <= n_pos;
                r_hdr_ok  <= n_hdr_ok;
                r_bit_err <= n_bit_err;
                r_misc    <= n_misc;
                r_data    <= n_data;
            end
        end
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= t_pos'(FRAME_USED))
        else $error("entry position beyond frame length");
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_last) |=> (r_pos == '0 && r_hdr_ok && !r_bit_err))
        else $error("frame state not cleared after last entry");
    a_ok_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_res.decode_ok |-> (o_res.data_word == '0 && o_res.misc_word == '0))
        else $error("failed decode carries nonzero words");
`endif

endmodule
